/* sv/pip_pkg.sv */
// Shared constants and types of the point-in-polygon tester.
package pip_pkg;

   localparam int unsigned COORD_BITS_DEFAULT = 16;

   // Outcome of one edge check, passed from an edge checker to the accumulator.
   typedef struct packed {
      logic on_edge;
      logic crossing;
   } edge_flags_type;

   // Control carried along the pipeline with each vertex beat.
   typedef struct packed {
      logic check_open;
      logic last;
   } stage_tag_type;

endpackage

/* sv/pip_if.sv */
// Handshake channels of the point-in-polygon tester: vertex requests and results.
interface pip_req_if
   import pip_pkg::*;
#(
   parameter int unsigned COORD_BITS = COORD_BITS_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic signed [COORD_BITS-1:0] vertex_x;
   logic signed [COORD_BITS-1:0] vertex_y;
   logic                         last_vertex;

   modport source (
      output valid, point_x, point_y, vertex_x, vertex_y, last_vertex,
      input  ready
   );
   modport sink (
      input  valid, point_x, point_y, vertex_x, vertex_y, last_vertex,
      output ready
   );
endinterface

interface pip_rsp_if;
   logic valid;
   logic ready;
   logic is_inside;
   logic on_boundary;

   modport source (
      output valid, is_inside, on_boundary,
      input  ready
   );
   modport sink (
      input  valid, is_inside, on_boundary,
      output ready
   );
endinterface

/* sv/pip_edge.sv */
// Two-stage checker of one polygon edge against the query point.
module pip_edge
   import pip_pkg::*;
#(
   parameter int unsigned COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         s1_load,
   input  logic                         s2_load,
   input  logic signed [COORD_BITS-1:0] a_x,
   input  logic signed [COORD_BITS-1:0] a_y,
   input  logic signed [COORD_BITS-1:0] b_x,
   input  logic signed [COORD_BITS-1:0] b_y,
   input  logic signed [COORD_BITS-1:0] p_x,
   input  logic signed [COORD_BITS-1:0] p_y,
   output edge_flags_type               flags
);

   localparam int unsigned DW = COORD_BITS + 1;
   localparam int unsigned PW = 2 * DW;
   localparam int unsigned XW = PW + 1;

   logic signed [DW-1:0] dx_in, dy_in, pdx_in, pdy_in;
   logic signed [DW-1:0] dx_ff, dy_ff, pdx_ff, pdy_ff;
   logic                 box_in, straddle_in, up_in;
   logic                 box1_ff, straddle1_ff, up1_ff;
   logic signed [PW-1:0] prod_a_in, prod_b_in;
   logic signed [PW-1:0] prod_a_ff, prod_b_ff;
   logic                 box2_ff, straddle2_ff, up2_ff;
   logic signed [XW-1:0] cross_prod;

   // Differences and the order tests come straight from the coordinates.
   assign dx_in  = DW'(b_x) - DW'(a_x);
   assign dy_in  = DW'(b_y) - DW'(a_y);
   assign pdx_in = DW'(p_x) - DW'(a_x);
   assign pdy_in = DW'(p_y) - DW'(a_y);

   assign box_in = ((a_x <= p_x && p_x <= b_x) || (b_x <= p_x && p_x <= a_x)) &&
                   ((a_y <= p_y && p_y <= b_y) || (b_y <= p_y && p_y <= a_y));
   assign straddle_in = (a_y > p_y) != (b_y > p_y);
   assign up_in       = b_y > a_y;

   always_ff @(posedge clock) begin
      if (s1_load) begin
         dx_ff        <= dx_in;
         dy_ff        <= dy_in;
         pdx_ff       <= pdx_in;
         pdy_ff       <= pdy_in;
         box1_ff      <= box_in;
         straddle1_ff <= straddle_in;
         up1_ff       <= up_in;
      end
   end

   assign prod_a_in = dx_ff * pdy_ff;
   assign prod_b_in = dy_ff * pdx_ff;

   always_ff @(posedge clock) begin
      if (s2_load) begin
         prod_a_ff    <= prod_a_in;
         prod_b_ff    <= prod_b_in;
         box2_ff      <= box1_ff;
         straddle2_ff <= straddle1_ff;
         up2_ff       <= up1_ff;
      end
   end

   // The sign of the cross product says on which side of the edge the point lies.
   assign cross_prod = XW'(prod_a_ff) - XW'(prod_b_ff);

   assign flags.on_edge  = box2_ff && (cross_prod == '0);
   assign flags.crossing = straddle2_ff && (up2_ff ? (cross_prod > 0) : (cross_prod < 0));

endmodule

/* sv/pip_acc.sv */
// Crossing parity and boundary accumulator with the result register.
module pip_acc
   import pip_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           retire,
   input  stage_tag_type  tag,
   input  edge_flags_type open_flags,
   input  edge_flags_type close_flags,
   pip_rsp_if.source      rsp_bus,
   output logic           slot_free
);

   logic parity_ff, parity_in;
   logic hit_ff, hit_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic is_inside_ff, on_boundary_ff;
   logic parity_new, hit_new;

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   // The open edge runs from the previous vertex, the closing edge back to the first.
   assign hit_new = hit_ff
                  || (tag.check_open && open_flags.on_edge)
                  || (tag.last && close_flags.on_edge);
   assign parity_new = parity_ff
                     ^ (tag.check_open && open_flags.crossing)
                     ^ (tag.last && close_flags.crossing);

   always_comb begin
      parity_in    = parity_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (retire) begin
         if (tag.last) begin
            parity_in    = 1'b0;
            hit_in       = 1'b0;
            rsp_valid_in = 1'b1;
         end else begin
            parity_in = parity_new;
            hit_in    = hit_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         parity_ff    <= parity_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (retire && tag.last) begin
         is_inside_ff   <= parity_new || hit_new;
         on_boundary_ff <= hit_new;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.is_inside   = is_inside_ff;
   assign rsp_bus.on_boundary = on_boundary_ff;

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      retire && tag.last |-> slot_free)
      else $error("result register overwritten while still held");
   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      retire && tag.last |=> rsp_valid_ff)
      else $error("closing vertex retired without a result");
   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      retire && tag.last |=> !parity_ff && !hit_ff)
      else $error("polygon state not cleared after a result");
   a_boundary_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (is_inside_ff || !on_boundary_ff))
      else $error("boundary point reported outside");
`endif

endmodule

/* sv/point_in_polygon_test.sv */
// Top level of the point-in-polygon tester: vertex intake, edge checkers and accumulator.
// A closing vertex goes via the intake and multiplier stages into the result register.
// Throughput: one vertex beat per cycle while no closing vertex waits on a held result.
// Reset is synchronous and active high; it empties the pipeline, clears the crossing
// parity and boundary flag, and readies the block for the first vertex of a polygon.
// There is no clearing pass: the block accepts beats as soon as reset is low.
module point_in_polygon_test
   import pip_pkg::*;
#(
   parameter int unsigned COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   pip_req_if.sink   req_bus,
   pip_rsp_if.source rsp_bus
);

   // Each vertex beat completes up to two edges: the open edge from the previous
   // vertex, and on the last vertex also the closing edge back to the first one.
   // Both are checked in parallel by identical two-stage checkers. Vertex
   // bookkeeping (first, previous, awaiting a new polygon) is done at intake,
   // since it depends only on the order of the beats.

   logic signed [COORD_BITS-1:0] first_x_ff, first_y_ff;
   logic signed [COORD_BITS-1:0] prev_x_ff, prev_y_ff;
   logic                         await_ff, await_in;
   logic                         v1_ff, v1_in, v2_ff, v2_in;
   stage_tag_type                tag1_ff, tag2_ff, tag_in;
   logic                         accept, move1, retire, slot_free;
   logic signed [COORD_BITS-1:0] close_x, close_y;
   edge_flags_type               open_flags, close_flags;

   // A last vertex needs the result register free; any other beat can always retire,
   // so the pipeline keeps draining while a result waits to be taken. No beat is
   // taken while reset is held, since it would be lost.
   assign retire        = v2_ff && (!tag2_ff.last || slot_free);
   assign move1         = v1_ff && (!v2_ff || retire);
   assign req_bus.ready = !reset && (!v1_ff || move1);
   assign accept        = req_bus.valid && req_bus.ready;

   assign tag_in.check_open = !await_ff;
   assign tag_in.last       = req_bus.last_vertex;

   // For a single-vertex polygon the closing edge degenerates to the vertex itself.
   assign close_x = await_ff ? req_bus.vertex_x : first_x_ff;
   assign close_y = await_ff ? req_bus.vertex_y : first_y_ff;

   always_comb begin
      v1_in    = v1_ff;
      v2_in    = v2_ff;
      await_in = await_ff;
      if (accept) begin
         v1_in    = 1'b1;
         await_in = req_bus.last_vertex;
      end else if (move1) begin
         v1_in = 1'b0;
      end
      if (move1) begin
         v2_in = 1'b1;
      end else if (retire) begin
         v2_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         await_ff   <= 1'b1;
         first_x_ff <= '0;
         first_y_ff <= '0;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
      end else begin
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         await_ff <= await_in;
         if (accept) begin
            if (await_ff) begin
               first_x_ff <= req_bus.vertex_x;
               first_y_ff <= req_bus.vertex_y;
            end
            prev_x_ff <= req_bus.vertex_x;
            prev_y_ff <= req_bus.vertex_y;
         end
      end
   end

   // The tags are payload that travels alongside the valid bits.
   always_ff @(posedge clock) begin
      if (accept) begin
         tag1_ff <= tag_in;
      end
      if (move1) begin
         tag2_ff <= tag1_ff;
      end
   end

   pip_edge #(
      .COORD_BITS (COORD_BITS)
   ) u_open_edge (
      .clock   (clock),
      .s1_load (accept),
      .s2_load (move1),
      .a_x     (prev_x_ff),
      .a_y     (prev_y_ff),
      .b_x     (req_bus.vertex_x),
      .b_y     (req_bus.vertex_y),
      .p_x     (req_bus.point_x),
      .p_y     (req_bus.point_y),
      .flags   (open_flags)
   );

   pip_edge #(
      .COORD_BITS (COORD_BITS)
   ) u_close_edge (
      .clock   (clock),
      .s1_load (accept),
      .s2_load (move1),
      .a_x     (req_bus.vertex_x),
      .a_y     (req_bus.vertex_y),
      .b_x     (close_x),
      .b_y     (close_y),
      .p_x     (req_bus.point_x),
      .p_y     (req_bus.point_y),
      .flags   (close_flags)
   );

   // The accumulator folds each retired beat into the parity and boundary flag,
   // and on the last vertex loads the result register.
   pip_acc u_acc (
      .clock       (clock),
      .reset       (reset),
      .retire      (retire),
      .tag         (tag2_ff),
      .open_flags  (open_flags),
      .close_flags (close_flags),
      .rsp_bus     (rsp_bus),
      .slot_free   (slot_free)
   );

`ifndef ASSERT_OFF
   a_stage2_held: assert property (@(posedge clock) disable iff (reset)
      v2_ff && !retire |=> v2_ff)
      else $error("stalled beat dropped from the multiplier stage");
   a_stage1_held: assert property (@(posedge clock) disable iff (reset)
      v1_ff && !move1 |=> v1_ff)
      else $error("stalled beat dropped from the intake stage");
   a_new_polygon: assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.last_vertex |=> await_ff)
      else $error("closing vertex did not start a new polygon");
`endif

endmodule

/* test/tb.sv */
// Self-checking testbench of the point-in-polygon tester, with a crossing-number predictor.
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_W = pip_pkg::COORD_BITS_DEFAULT;

   // A long enough spell with no beat moving on either channel means the block has hung.
   localparam int STALL_LIMIT = 2000;

   // Cycles for which the receiver refuses results during the back-pressure phase.
   localparam int LONG_HOLD_CYCLES = 300;

   // Cycles allowed after the last result for a stray beat to show itself.
   localparam int TAIL_CYCLES = 8;

   localparam int RANDOM_ITEMS = 800;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      logic is_inside;
      logic on_boundary;
   } verdict_type;

   typedef struct packed {
      coord_type px;
      coord_type py;
      coord_type vx;
      coord_type vy;
      logic      last;
   } vertex_beat_type;

   // Holds the crossing-number state of the polygon in progress and the verdicts
   // that closed polygons are owed, oldest first.
   class polygon_verdict_board;
      verdict_type expected_q[$];
      coord_type   first_x = '0;
      coord_type   first_y = '0;
      coord_type   prev_x = '0;
      coord_type   prev_y = '0;
      bit          parity = 1'b0;
      bit          on_edge_seen = 1'b0;
      bit          await_first = 1'b1;
      int          polygons_checked = 0;

      // Edge a->b against point p: exact cross product, half-open crossing rule.
      function void test_edge(coord_type ax, coord_type ay, coord_type bx, coord_type by,
                              coord_type px, coord_type py);
         longint cross_prod;
         bit     left;
         cross_prod = (longint'(bx) - longint'(ax)) * (longint'(py) - longint'(ay))
                    - (longint'(by) - longint'(ay)) * (longint'(px) - longint'(ax));
         if (cross_prod == 0 &&
             px >= ((ax < bx) ? ax : bx) && px <= ((ax > bx) ? ax : bx) &&
             py >= ((ay < by) ? ay : by) && py <= ((ay > by) ? ay : by))
            on_edge_seen = 1'b1;
         if ((ay > py) != (by > py)) begin
            left = (by > ay) ? (cross_prod > 0) : (cross_prod < 0);
            if (left)
               parity = !parity;
         end
      endfunction

      function void note_vertex(vertex_beat_type beat);
         verdict_type verdict;
         if (await_first) begin
            first_x = beat.vx;
            first_y = beat.vy;
            await_first = 1'b0;
         end else begin
            test_edge(prev_x, prev_y, beat.vx, beat.vy, beat.px, beat.py);
         end
         prev_x = beat.vx;
         prev_y = beat.vy;
         if (beat.last) begin
            test_edge(beat.vx, beat.vy, first_x, first_y, beat.px, beat.py);
            verdict.is_inside = parity | on_edge_seen;
            verdict.on_boundary = on_edge_seen;
            expected_q.push_back(verdict);
            parity = 1'b0;
            on_edge_seen = 1'b0;
            await_first = 1'b1;
         end
      endfunction

      // Returns an empty string when the result matches the oldest verdict owed.
      function string check_verdict(logic got_inside, logic boundary);
         verdict_type want;
         string       msg;
         msg = "";
         if (expected_q.size() == 0)
            return $sformatf("result beat (%b,%b) with no polygon closed", got_inside, boundary);
         want = expected_q.pop_front();
         if (got_inside !== want.is_inside)
            msg = $sformatf("polygon %0d: is_inside %b, predicted %b ",
                            polygons_checked, got_inside, want.is_inside);
         if (boundary !== want.on_boundary)
            msg = {msg, $sformatf("polygon %0d: on_boundary %b, predicted %b",
                                  polygons_checked, boundary, want.on_boundary)};
         polygons_checked++;
         return msg;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   pip_req_if #(.COORD_BITS(COORD_W)) req_bus ();
   pip_rsp_if                         rsp_bus ();

   point_in_polygon_test #(.COORD_BITS(COORD_W)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   polygon_verdict_board board;

   int mismatch_count = 0;
   int idle_cycles = 0;
   int items_sent = 0;

   // When set, the sender or the receiver stops idling between beats.
   bit sender_steady = 1'b0;
   bit receiver_steady = 1'b0;

   // Written by the stimulus process, consumed by the receiver at its next result.
   int long_hold_request = 0;

   initial clock = 1'b0;
   always #5ns clock = ~clock;

   task automatic report_mismatch(string what);
      $display("ERROR at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   // Every beat that crosses either channel is seen here at the rising edge. The vertex
   // is noted before any result is checked, so a block that answered within the same
   // cycle would still be judged fairly. The stall watchdog lives here too.
   always @(posedge clock) begin
      vertex_beat_type beat;
      string           msg;
      bit              moved;
      moved = 1'b0;
      if (req_bus.valid && req_bus.ready) begin
         beat.px = req_bus.point_x;
         beat.py = req_bus.point_y;
         beat.vx = req_bus.vertex_x;
         beat.vy = req_bus.vertex_y;
         beat.last = req_bus.last_vertex;
         board.note_vertex(beat);
         moved = 1'b1;
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
         msg = board.check_verdict(rsp_bus.is_inside, rsp_bus.on_boundary);
         if (msg != "")
            report_mismatch(msg);
         moved = 1'b1;
      end
      if (moved || reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("ERROR: no beat moved for %0d cycles, %0d verdicts still owed",
                     STALL_LIMIT, board.pending());
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Receiver: before each result it waits a random number of cycles, or none at all
   // while it is in a steady spell, or a long stretch when the stimulus asks for one.
   initial begin
      int hold;
      rsp_bus.ready = 1'b0;
      forever begin
         hold = receiver_steady ? 0 : $urandom_range(0, 18);
         if (long_hold_request > 0) begin
            hold = long_hold_request;
            long_hold_request = 0;
         end
         repeat (hold) @(negedge clock) rsp_bus.ready <= 1'b0;
         @(negedge clock) rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         if ($urandom_range(0, 23) == 0)
            receiver_steady = !receiver_steady;
      end
   end

   // Offers one vertex beat after a random gap and returns at the edge that takes it.
   // Valid is left high so that a following beat can go out without a bubble.
   task automatic send_vertex(coord_type px, coord_type py, coord_type vx, coord_type vy,
                              logic last);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 18);
      repeat (gap) @(negedge clock) req_bus.valid <= 1'b0;
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.point_x <= px;
      req_bus.point_y <= py;
      req_bus.vertex_x <= vx;
      req_bus.vertex_y <= vy;
      req_bus.last_vertex <= last;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   // Sends a whole polygon of up to four corners, given as x, y pairs.
   task automatic send_polygon(int px, int py, int count, int corners[8]);
      for (int i = 0; i < count; i++)
         send_vertex(COORD_W'(px), COORD_W'(py), COORD_W'(corners[2*i]),
                     COORD_W'(corners[2*i+1]), i == count - 1);
   endtask

   // Lowers valid and holds the sender back until every owed verdict has come.
   task automatic wait_drained();
      @(negedge clock) req_bus.valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
   endtask

   // One coordinate from a range picked by the caller: a tight cluster so that
   // collinear edges and boundary hits are common, a moderate range, the full range
   // so that every bit toggles, or one of the extremes of the field.
   function automatic coord_type draw_coord(int spread);
      int v;
      case (spread)
         0: v = int'($urandom_range(0, 16)) - 8;
         1: v = int'($urandom_range(0, 400)) - 200;
         2: v = int'($urandom());
         default:
            case ($urandom_range(0, 6))
               0: v = -32768;
               1: v = -32767;
               2: v = -1;
               3: v = 0;
               4: v = 1;
               5: v = 32766;
               default: v = 32767;
            endcase
      endcase
      return COORD_W'(v);
   endfunction

   // A random polygon of one to twelve vertices, mostly short. The query point is
   // often placed on a vertex or near an edge, and now and then moves mid-polygon.
   task automatic send_random_polygon(int max_count);
      coord_type xs[12];
      coord_type ys[12];
      coord_type px;
      coord_type py;
      int        count;
      int        spread;
      int        k;
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(1, max_count)
                                          : $urandom_range(1, (max_count < 6) ? max_count : 6);
      spread = $urandom_range(0, 3);
      for (int i = 0; i < count; i++) begin
         xs[i] = draw_coord(spread);
         ys[i] = draw_coord(spread);
      end
      k = $urandom_range(0, count - 1);
      case ($urandom_range(0, 4))
         0: begin
            px = xs[k];
            py = ys[k];
         end
         1: begin
            px = COORD_W'((int'(xs[k]) + int'(xs[(k + 1) % count])) / 2);
            py = COORD_W'((int'(ys[k]) + int'(ys[(k + 1) % count])) / 2);
         end
         default: begin
            px = draw_coord(spread);
            py = draw_coord(spread);
         end
      endcase
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 15) == 0) begin
            px = draw_coord(spread);
            py = draw_coord(spread);
         end
         send_vertex(px, py, xs[i], ys[i], i == count - 1);
      end
   endtask

   initial begin
      bit back_pressure_done;
      back_pressure_done = 1'b0;
      board = new();
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.point_x = '0;
      req_bus.point_y = '0;
      req_bus.vertex_x = '0;
      req_bus.vertex_y = '0;
      req_bus.last_vertex = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed polygons. The full-range square is tested with its centre, a point on
      // its left side and its top right corner, which stretches the cross product to
      // its widest.
      send_polygon(0, 0, 4, '{-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767});
      send_polygon(-32768, 0, 4, '{-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767});
      send_polygon(32767, 32767, 4, '{-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767});

      // A lone vertex closes onto itself: a hit only when the point sits on it.
      send_polygon(-32768, 32767, 1, '{-32768, 32767, 0, 0, 0, 0, 0, 0});
      send_polygon(5, 5, 1, '{6, 5, 0, 0, 0, 0, 0, 0});

      // Two vertices: the crossings cancel, so only the boundary can make it inside.
      send_polygon(0, 0, 2, '{-4, -4, 4, 4, 0, 0, 0, 0});

      // The ray passes through a vertex of the triangle; the half-open rule must count
      // just one of the edges that meet there, leaving the point outside.
      send_polygon(0, 0, 3, '{10, 0, 20, 10, 20, -10, 0, 0});

      // A horizontal edge lies along the ray but well to the right of the point.
      send_polygon(0, 5, 4, '{10, 5, 20, 5, 20, 15, 10, 15});

      // The point moves between vertices; each edge is judged against the point
      // carried by the beat that completes it.
      send_vertex(5, 5, 0, 0, 1'b0);
      send_vertex(5, 0, 10, 0, 1'b0);
      send_vertex(-3, 7, 10, 10, 1'b0);
      send_vertex(2, 2, 0, 10, 1'b1);
      wait_drained();

      // Random polygons, with quiet and busy spells on the sending side. Half way
      // through, the receiver holds off for a long stretch while short polygons keep
      // arriving back to back, so the block fills and must stall its input.
      while (items_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0)
            sender_steady = !sender_steady;
         if (!back_pressure_done && items_sent >= RANDOM_ITEMS / 2) begin
            wait_drained();
            long_hold_request = LONG_HOLD_CYCLES;
            sender_steady = 1'b1;
            repeat (40)
               send_random_polygon(2);
            sender_steady = 1'b0;
            wait_drained();
            back_pressure_done = 1'b1;
         end
         send_random_polygon(12);
      end

      // Everything owed must arrive, and nothing further may follow it.
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

/* filelist.f */
sv/pip_pkg.sv
sv/pip_if.sv
sv/pip_edge.sv
sv/pip_acc.sv
sv/point_in_polygon_test.sv
test/tb.sv
